[design/signed_int_to_decimal_ascii_macros.svh]
// Assertion macros used by the checker module of the decimal text converter.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_MACROS_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SID_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SID_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

[design/sid_pkg.sv]
// Package with shared types, constants and functions of the decimal text converter.
package sid_pkg;

    // Default width of the signed input word.
    localparam int VALUE_WIDTH_DEF = 16;

    // ASCII codes used in the output text.
    localparam logic [6:0] CHAR_MINUS = 7'h2D;
    localparam logic [6:0] CHAR_ZERO  = 7'h30;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_TRIM,
        ST_SIGN,
        ST_EMIT
    } t_state;

    // Operations of the shared BCD unit.
    typedef enum logic [1:0] {
        BCD_HOLD,
        BCD_LOAD,
        BCD_STEP,
        BCD_SHIFT
    } t_bcd_op;

    // Number of decimal digits needed for the largest magnitude, 2^(w-1).
    function automatic int dec_digits(input int w);
        longint v;
        int     n;
        v = longint'(1) << (w - 1);
        n = 0;
        while (v > 0) begin
            v = v / 10;
            n = n + 1;
        end
        return n;
    endfunction

endpackage

[design/signed_int_to_decimal_ascii.sv]
// Top level of the signed integer to decimal ASCII text converter.
// A word is taken when start is high and busy is low. The block then runs
// one shared double-dabble unit over the magnitude (one magnitude bit per
// cycle), drops leading zero digits at one digit per cycle and then ends
// trimming, and sends the text one character per cycle: an optional
// '-' and then the digits, most significant first, with o_last on the final
// one. Each character shows on o_ascii_char for a single cycle marked by
// o_strobe; the receiver cannot stall it. Busy drops in the cycle that
// shows the final character, so a new word can be taken in that cycle.
module signed_int_to_decimal_ascii
    import sid_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [VALUE_WIDTH-1:0] i_value,
    output logic                          o_strobe,
    output logic [6:0]                    o_ascii_char,
    output logic                          o_last
);

    localparam int NUM_DIGITS = dec_digits(VALUE_WIDTH);
    localparam int CW         = $clog2(VALUE_WIDTH + 1);
    localparam int DW         = $clog2(NUM_DIGITS + 1);

    t_state                 r_state, n_state;
    logic [CW-1:0]          r_cnt, n_cnt;
    logic [DW-1:0]          r_dig, n_dig;
    logic                   r_neg, n_neg;
    logic                   r_strobe, n_strobe;
    logic [6:0]             r_char, n_char;
    logic                   r_last, n_last;
    t_bcd_op                w_op;
    logic [VALUE_WIDTH-1:0] w_raw;
    logic [VALUE_WIDTH-1:0] w_mag;
    logic [3:0]             w_top;

    // Magnitude of the input; the most negative value maps to 2^(VALUE_WIDTH-1).
    assign w_raw = i_value;
    assign w_mag = w_raw[VALUE_WIDTH-1] ? (~w_raw + VALUE_WIDTH'(1)) : w_raw;

    sid_bcd_unit #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .NUM_DIGITS  (NUM_DIGITS)
    ) u_bcd (
        .i_clk       (i_clk),
        .i_op        (w_op),
        .i_mag       (w_mag),
        .o_top_digit (w_top)
    );

    // Next state and datapath control of the sequencer.
    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_dig    = r_dig;
        n_neg    = r_neg;
        n_strobe = 1'b0;
        n_char   = r_char;
        n_last   = r_last;
        w_op     = BCD_HOLD;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    w_op    = BCD_LOAD;
                    n_neg   = w_raw[VALUE_WIDTH-1];
                    n_cnt   = CW'(VALUE_WIDTH);
                    n_state = ST_CONV;
                end
            end
            ST_CONV: begin
                w_op  = BCD_STEP;
                n_cnt = r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    n_dig   = DW'(NUM_DIGITS);
                    n_state = ST_TRIM;
                end
            end
            ST_TRIM: begin
                if (r_dig > DW'(1) && w_top == 4'd0) begin
                    w_op  = BCD_SHIFT;
                    n_dig = r_dig - DW'(1);
                end else begin
                    n_state = r_neg ? ST_SIGN : ST_EMIT;
                end
            end
            ST_SIGN: begin
                n_strobe = 1'b1;
                n_char   = CHAR_MINUS;
                n_last   = 1'b0;
                n_state  = ST_EMIT;
            end
            ST_EMIT: begin
                n_strobe = 1'b1;
                n_char   = CHAR_ZERO + {3'b000, w_top};
                n_last   = (r_dig == DW'(1));
                w_op     = BCD_SHIFT;
                n_dig    = r_dig - DW'(1);
                if (r_dig == DW'(1)) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
        end
    end

    // Counters and output word registers.
    always_ff @(posedge i_clk) begin
        r_cnt  <= n_cnt;
        r_dig  <= n_dig;
        r_neg  <= n_neg;
        r_char <= n_char;
        r_last <= n_last;
    end

    assign busy         = (r_state != ST_IDLE);
    assign o_strobe     = r_strobe;
    assign o_ascii_char = r_char;
    assign o_last       = r_last;

endmodule

[design/sid_bcd_unit.sv]
// Shared double-dabble unit: binary to BCD conversion one bit per cycle, then digit shift-out.
module sid_bcd_unit
    import sid_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
    parameter int NUM_DIGITS  = dec_digits(VALUE_WIDTH)
) (
    input  logic                   i_clk,
    input  t_bcd_op                i_op,
    input  logic [VALUE_WIDTH-1:0] i_mag,
    output logic [3:0]             o_top_digit
);

    localparam int BCD_W = 4 * NUM_DIGITS;

    logic [VALUE_WIDTH-1:0] r_mag;
    logic [BCD_W-1:0]       r_bcd;
    logic [BCD_W-1:0]       w_adj;

    // Add three to every digit of five or more before the next shift.
    always_comb begin
        for (int d = 0; d < NUM_DIGITS; d++) begin
            if (r_bcd[4*d +: 4] >= 4'd5) begin
                w_adj[4*d +: 4] = r_bcd[4*d +: 4] + 4'd3;
            end else begin
                w_adj[4*d +: 4] = r_bcd[4*d +: 4];
            end
        end
    end

    // Load, shift in one magnitude bit, or shift the digit word up by one digit.
    always_ff @(posedge i_clk) begin
        unique case (i_op)
            BCD_LOAD: begin
                r_mag <= i_mag;
                r_bcd <= '0;
            end
            BCD_STEP: begin
                r_bcd <= {w_adj[BCD_W-2:0], r_mag[VALUE_WIDTH-1]};
                r_mag <= {r_mag[VALUE_WIDTH-2:0], 1'b0};
            end
            BCD_SHIFT: begin
                r_bcd <= {r_bcd[BCD_W-5:0], 4'd0};
            end
            BCD_HOLD: begin
                r_bcd <= r_bcd;
            end
        endcase
    end

    assign o_top_digit = r_bcd[BCD_W-1 -: 4];

endmodule

[design/sid_checker.sv]
// Port-level checker for the decimal text converter, bound to the top level.
`include "signed_int_to_decimal_ascii_macros.svh"

module sid_checker
    import sid_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       o_strobe,
    input logic [6:0] o_ascii_char,
    input logic       o_last
);

    logic w_char_ok;

    // A legal word is a minus sign or a decimal digit.
    assign w_char_ok = (o_ascii_char == CHAR_MINUS) ||
                       ((o_ascii_char >= CHAR_ZERO) && (o_ascii_char <= (CHAR_ZERO + 7'd9)));

    // Every issued word is a minus sign or a decimal digit.
    `SID_ASSERT_IMPLY(a_char_legal, i_clk, i_rst_n, o_strobe, w_char_ok)

    // An accepted word keeps the block busy in the next cycle.
    `SID_ASSERT_NEXT(a_busy_after_start, i_clk, i_rst_n, start && !busy, busy)

    // The final character frees the block; an earlier one does not.
    `SID_ASSERT_IMPLY(a_last_frees, i_clk, i_rst_n, o_strobe, o_last != busy)

    // A minus sign is never the final character.
    `SID_ASSERT_IMPLY(a_minus_not_last, i_clk, i_rst_n, o_strobe && (o_ascii_char == CHAR_MINUS), !o_last)

endmodule

bind signed_int_to_decimal_ascii sid_checker u_sid_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_strobe     (o_strobe),
    .o_ascii_char (o_ascii_char),
    .o_last       (o_last)
);
